/* src/mmsa_pkg.sv */
// ----------------------------------------------------------------------------
// mmsa_pkg: shared types and constants for the modular multiplier
// Holds the controller state type, the command and status bundles passed
// between controller and datapath, and the default operand width.
// ----------------------------------------------------------------------------
package mmsa_pkg;

  // Width of every payload and configuration field on the ports.
  localparam int FIELD_W = 64;

  // Default number of operand bits that take part in the arithmetic.
  localparam int OPERAND_WIDTH_DEF = 64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MULT,
    ST_HOLD
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // capture a new transaction's operands
    logic reduce_step;  // one restoring-division step on the multiplicand
    logic mult_step;    // one double-and-add step on the multiplier
    logic out_load;     // move the finished result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mod_zero;     // the configured modulus is zero
  } sts_t;

endpackage

/* src/mmsa_ctrl.sv */
// ----------------------------------------------------------------------------
// mmsa_ctrl: sequencer for the modular multiplier
// Walks each transaction through the reduction and multiplication phases (both
// skipped for a zero modulus), counts the steps of each phase and owns the output valid flag.
// ----------------------------------------------------------------------------
module mmsa_ctrl #(
  parameter int OPERAND_WIDTH = mmsa_pkg::OPERAND_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  mmsa_pkg::sts_t sts,
  output mmsa_pkg::cmd_t cmd
);
  import mmsa_pkg::*;

  localparam int CW = $clog2(OPERAND_WIDTH);

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          last;

  assign last      = (cnt_r == CW'(OPERAND_WIDTH - 1));
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = sts.mod_zero ? ST_HOLD : ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        cmd.reduce_step = 1'b1;
        if (last) begin
          cnt_nxt   = '0;
          state_nxt = ST_MULT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_MULT: begin
        cmd.mult_step = 1'b1;
        if (last) begin
          state_nxt = ST_HOLD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_HOLD: begin
        // Wait here until the output register is free or being emptied.
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* src/mmsa_dp.sv */
// ----------------------------------------------------------------------------
// mmsa_dp: datapath of the modular multiplier
// Holds the modulus, the operand shift registers, the running remainder and
// accumulator, and the output register. Each reduction step is one conditional
// subtraction and each multiplication step two, on one-bit-wider intermediates.
// ----------------------------------------------------------------------------
module mmsa_dp #(
  parameter int OPERAND_WIDTH = mmsa_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [mmsa_pkg::FIELD_W-1:0] cfg_wr_data,
  input  logic [mmsa_pkg::FIELD_W-1:0] in_multiplicand,
  input  logic [mmsa_pkg::FIELD_W-1:0] in_multiplier,
  input  mmsa_pkg::cmd_t               cmd,
  output mmsa_pkg::sts_t               sts,
  output logic [mmsa_pkg::FIELD_W-1:0] out_product,
  output logic                         out_zero_modulus_error
);
  import mmsa_pkg::*;

  localparam int W = OPERAND_WIDTH;

  logic [W-1:0]       mod_r;
  logic [W-1:0]       a_sh_r, a_sh_nxt;
  logic [W-1:0]       rem_r, rem_nxt;
  logic [W-1:0]       b_r, b_nxt;
  logic [W-1:0]       acc_r, acc_nxt;
  logic               err_r, err_nxt;
  logic [FIELD_W-1:0] product_r;
  logic               out_err_r;

  logic [W:0] div_trial, sum_acc, sum_dbl, mod_x;

  assign mod_x        = {1'b0, mod_r};
  assign sts.mod_zero = (mod_r == '0);

  // The modulus register resets to one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= W'(1);
    end else if (cfg_wr_en) begin
      mod_r <= cfg_wr_data[W-1:0];
    end
  end

  always_comb begin
    a_sh_nxt  = a_sh_r;
    rem_nxt   = rem_r;
    b_nxt     = b_r;
    acc_nxt   = acc_r;
    err_nxt   = err_r;
    div_trial = {rem_r, a_sh_r[W-1]};
    sum_acc   = {1'b0, acc_r} + {1'b0, rem_r};
    sum_dbl   = {rem_r, 1'b0};
    if (cmd.load) begin
      a_sh_nxt = in_multiplicand[W-1:0];
      b_nxt    = in_multiplier[W-1:0];
      rem_nxt  = '0;
      acc_nxt  = '0;
      err_nxt  = sts.mod_zero;
    end else if (cmd.reduce_step) begin
      a_sh_nxt = {a_sh_r[W-2:0], 1'b0};
      rem_nxt  = (div_trial >= mod_x) ? W'(div_trial - mod_x) : div_trial[W-1:0];
    end else if (cmd.mult_step) begin
      b_nxt = {1'b0, b_r[W-1:1]};
      if (b_r[0]) begin
        acc_nxt = (sum_acc >= mod_x) ? W'(sum_acc - mod_x) : sum_acc[W-1:0];
      end
      rem_nxt = (sum_dbl >= mod_x) ? W'(sum_dbl - mod_x) : sum_dbl[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    a_sh_r <= a_sh_nxt;
    rem_r  <= rem_nxt;
    b_r    <= b_nxt;
    acc_r  <= acc_nxt;
    err_r  <= err_nxt;
    if (cmd.out_load) begin
      product_r <= FIELD_W'(acc_r);
      out_err_r <= err_r;
    end
  end

  assign out_product            = product_r;
  assign out_zero_modulus_error = out_err_r;

endmodule

/* src/modular_multiply_shift_add.sv */
// ----------------------------------------------------------------------------
// modular_multiply_shift_add: interleaved modular multiplier
// Returns (multiplicand * multiplier) mod modulus, one result per transaction.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall, in_multiplicand, in_multiplier)
// takes one transaction whenever in_valid is high and in_stall is low. The
// result channel (out_valid, out_stall, out_product, out_zero_modulus_error)
// delivers one transaction per input in the same order.
// The modulus is written through cfg_wr_en / cfg_wr_data; the user must write it
// only while the block is idle, which the block itself does not enforce. Reset
// sets it to one. A zero modulus gives product 0 with the error flag set, and
// that transaction skips the arithmetic entirely. A result comes from the
// one-bit-per-cycle restoring reduction of the multiplicand, then one
// double-and-add step per multiplier bit, then the hold state that loads the
// output register; the next transaction is taken once the sequencer is idle
// again. With a zero modulus the transaction goes from acceptance straight to
// the hold state.
// One transaction is in flight at a time; in_stall is high from acceptance
// until the result enters the output register. A stalled result holds in
// the output register while the next transaction is already accepted and
// computed; that one then waits until the output register is taken.
// Reset (rst_n low, synchronous) empties the block and restores the modulus.
// ----------------------------------------------------------------------------
module modular_multiply_shift_add #(
  parameter int OPERAND_WIDTH = mmsa_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [mmsa_pkg::FIELD_W-1:0] cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [mmsa_pkg::FIELD_W-1:0] in_multiplicand,
  input  logic [mmsa_pkg::FIELD_W-1:0] in_multiplier,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mmsa_pkg::FIELD_W-1:0] out_product,
  output logic                         out_zero_modulus_error
);
  import mmsa_pkg::*;

  // Command and status bundles between the sequencer and the datapath.
  cmd_t cmd;
  sts_t sts;

  // The controller sequences the phases and owns both handshake flags.
  mmsa_ctrl #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the modulus, the operands and the output register.
  mmsa_dp #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_wr_data            (cfg_wr_data),
    .in_multiplicand        (in_multiplicand),
    .in_multiplier          (in_multiplier),
    .cmd                    (cmd),
    .sts                    (sts),
    .out_product            (out_product),
    .out_zero_modulus_error (out_zero_modulus_error)
  );

`ifndef SYNTHESIS
  // An accepted transaction keeps the input side stalled in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after an accepted transaction");

  // A flagged result always carries a zero product.
  a_error_zero_product: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_modulus_error) |-> (out_product == '0))
    else $error("zero-modulus result with nonzero product");

  // The sequencer never issues two datapath commands at once.
  a_single_command: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command in a cycle");

  // A new result is loaded only when the output register is free or draining.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("output register overwritten while stalled");
`endif

endmodule

/* test/modular_multiply_shift_add_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modular_multiply_shift_add_tb: self-checking bench for the modular multiplier
// Drives operand pairs through the valid/stall input channel under several
// modulus settings and predicts each product with a full-width 128-bit
// multiply and remainder. Every result is compared field by field, in order,
// against the oldest prediction. Both channels idle at random, first with a
// slow receiver, then with a slow sender, and finally with no idling at all.
// ----------------------------------------------------------------------------
module modular_multiply_shift_add_tb;

  import mmsa_pkg::*;

  localparam int W = FIELD_W;
  // Cycles in which nothing moves on either channel before the run is abandoned.
  localparam int HANG_LIMIT = 4000;
  // Settling time after the last result, derived from the default operand width.
  localparam int SETTLE_CYCLES = 2 * OPERAND_WIDTH_DEF + 4;
  localparam int RANDOM_ITEMS = 800;

  localparam logic [W-1:0] ALL_ONES = {W{1'b1}};
  localparam logic [W-1:0] TOP_BIT  = {1'b1, {(W-1){1'b0}}};

  // One expected result transaction.
  typedef struct {
    logic [W-1:0] product;
    logic         zero_modulus_error;
  } mod_result_t;

  // Scoreboard: tracks the modulus the block should be using and the queue of
  // products that are still owed by the block.
  class mod_product_board;
    logic [W-1:0] modulus;
    mod_result_t  owed[$];
    int           errors;

    function new();
      modulus = W'(1);
      errors  = 0;
    endfunction

    // An accepted operand pair: work out its product under the current modulus.
    function void note_operands(logic [W-1:0] a, logic [W-1:0] b);
      mod_result_t     r;
      logic [2*W-1:0]  wide;
      if (modulus == '0) begin
        r.product            = '0;
        r.zero_modulus_error = 1'b1;
      end else begin
        wide                 = ({{W{1'b0}}, a} * {{W{1'b0}}, b}) % {{W{1'b0}}, modulus};
        r.product            = wide[W-1:0];
        r.zero_modulus_error = 1'b0;
      end
      owed.push_back(r);
    endfunction

    function void check_result(logic [W-1:0] product, logic zero_modulus_error);
      mod_result_t r;
      if (owed.size() == 0) begin
        $error("unexpected result transaction: product %h, zero_modulus_error %b",
               product, zero_modulus_error);
        errors++;
      end else begin
        r = owed.pop_front();
        if (product !== r.product) begin
          $error("product: expected %h, actual %h", r.product, product);
          errors++;
        end
        if (zero_modulus_error !== r.zero_modulus_error) begin
          $error("zero_modulus_error: expected %b, actual %b",
                 r.zero_modulus_error, zero_modulus_error);
          errors++;
        end
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_wr_en = 1'b0;
  logic [W-1:0] cfg_wr_data = '0;
  logic         in_valid = 1'b0;
  logic         in_stall;
  logic [W-1:0] in_multiplicand = '0;
  logic [W-1:0] in_multiplier = '0;
  logic         out_valid;
  logic         out_stall = 1'b0;
  logic [W-1:0] out_product;
  logic         out_zero_modulus_error;

  // Percent chance per cycle that the sender holds back or the receiver stalls.
  int send_idle_pct = 23;
  int recv_idle_pct = 82;
  int quiet_cycles = 0;

  mod_product_board board = new();

  modular_multiply_shift_add u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_wr_data            (cfg_wr_data),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_multiplicand        (in_multiplicand),
    .in_multiplier          (in_multiplier),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_product            (out_product),
    .out_zero_modulus_error (out_zero_modulus_error)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // The receiver stalls at random; with a zero percentage it never stalls.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Result monitor and hang watchdog. Outputs are read right at the edge, so
  // they hold the values that the block presented to that edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_result(out_product, out_zero_modulus_error);
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [W-1:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // Operand values are biased toward the edges of the current modulus, since
  // that is where the reduction and the conditional subtractions get exercised.
  function automatic logic [W-1:0] pick_operand(logic [W-1:0] m);
    case ($urandom_range(9))
      0: return W'($urandom_range(15));
      1: return m - W'(1);
      2: return m;
      3: return m + W'($urandom_range(3));
      4: return ALL_ONES - W'($urandom_range(3));
      5: return TOP_BIT | random_word();
      default: return random_word();
    endcase
  endfunction

  function automatic logic [W-1:0] pick_modulus();
    case ($urandom_range(9))
      0: return '0;
      1: return W'(1);
      2: return W'($urandom_range(1000, 2));
      3: return W'(1) << $urandom_range(W - 1);
      4: return ALL_ONES - W'($urandom_range(7));
      5, 6: return TOP_BIT | random_word();
      default: return random_word();
    endcase
  endfunction

  // Stop sending and hold until every owed result has come back. The queue is
  // polled on the falling edge so the check at the rising edge has settled.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // A modulus change is only legal while the block is idle.
  task automatic set_modulus(logic [W-1:0] m);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    board.modulus = m;
  endtask

  // Offer one operand pair and hold it steady until the block takes it.
  task automatic send_operands(logic [W-1:0] a, logic [W-1:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid        <= 1'b1;
    in_multiplicand <= a;
    in_multiplier   <= b;
    do @(posedge clk); while (in_stall);
    board.note_operands(a, b);
  endtask

  initial begin
    int           sent;
    int           burst;
    logic [W-1:0] m;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. The reset value of the modulus is one, so every product
    // must come back as zero without the error flag.
    send_operands(ALL_ONES, ALL_ONES);
    send_operands(TOP_BIT, W'(3));

    // A zero modulus skips the arithmetic and flags the error.
    set_modulus('0);
    send_operands(ALL_ONES, ALL_ONES);
    send_operands('0, '0);

    // Largest modulus: zero, small and top-bit operands, and operands at and just below it.
    set_modulus(ALL_ONES);
    send_operands('0, '0);
    send_operands(ALL_ONES, ALL_ONES);
    send_operands(ALL_ONES - W'(1), ALL_ONES - W'(1));
    send_operands(ALL_ONES - W'(1), W'(2));
    send_operands(W'(1), ALL_ONES - W'(1));
    send_operands(TOP_BIT, W'(2));

    // Modulus just above the top bit, where the doubling carries into bit 64.
    set_modulus(TOP_BIT | W'(1));
    send_operands(ALL_ONES, ALL_ONES);
    send_operands(TOP_BIT, TOP_BIT);
    send_operands(ALL_ONES, W'(1));

    // A small modulus, with some operands far above it.
    set_modulus(W'(7));
    send_operands('0, ALL_ONES);
    send_operands(ALL_ONES, W'(1));
    send_operands(W'(5), W'(6));

    // Explicit modulus of one once more after other settings.
    set_modulus(W'(1));
    send_operands(random_word(), random_word());

    // Random part: bursts of operand pairs, each under a freshly written
    // modulus. The idling pattern changes at one and two thirds of the way.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      set_modulus(pick_modulus());
      m = board.modulus;
      burst = $urandom_range(60, 20);
      for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
        if (sent == RANDOM_ITEMS / 3) begin
          send_idle_pct = 82;
          recv_idle_pct = 23;
        end else if (sent == 2 * RANDOM_ITEMS / 3) begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        // Now and then the sender waits for the block to empty completely.
        if ($urandom_range(49) == 0) begin
          wait_drained();
        end
        send_operands(pick_operand(m), pick_operand(m));
        sent++;
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
